>>> rtl/nprq_pkg.sv
package nprq_pkg;

    localparam int ENTRIES = 64;
    localparam int CNTW    = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        KIND_RECORD   = 2'd0,
        KIND_OVERFLOW = 2'd1,
        KIND_NOMATCH  = 2'd2
    } t_kind;

    typedef struct packed {
        logic        done;
        logic [3:0]  channel;
        logic [31:0] start;
        logic [31:0] duration;
        logic [6:0]  tone;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic        shift;
        logic [3:0]  q_channel;
        logic [6:0]  q_tone;
        logic [31:0] q_time;
        t_entry      wdata;
    } t_cell_ctl;

endpackage

>>> rtl/nprq_cell.sv
module nprq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nprq_pkg::t_cell_ctl i_ctl,
    input  logic               i_wr,
    input  logic               i_occ,
    input  logic               i_tok,
    input  nprq_pkg::t_entry   i_next,
    output nprq_pkg::t_entry   o_entry,
    output logic               o_tok,
    output logic               o_hit
);

    nprq_pkg::t_entry r_entry, n_entry;
    logic             r_tok;

    // oldest undone match claims the search token
    assign o_hit = r_tok && i_occ && !r_entry.done
                   && (r_entry.channel == i_ctl.q_channel)
                   && (r_entry.tone == i_ctl.q_tone);
    assign o_tok   = r_tok && !o_hit;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_wr) begin
            n_entry = i_ctl.wdata;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end else if (o_hit) begin
            n_entry.done     = 1'b1;
            n_entry.duration = i_ctl.q_time - r_entry.start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

endmodule

>>> rtl/note_pairing_retire_queue_core.sv
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | mode, channel, event_time, tone
// output  | out       | o_valid / i_stall  | kind, gap_ticks, gap_present, gap_implied,
//         |           |                    | group_break, tone_out, duration, last
//
// note on: written into the next free cell, or an overflow result when the ring is full
// note off: a search token walks the cell chain one cell a cycle, then one retired
// record per cycle as long as the head is done and the output is not stalled
// reset is synchronous and clears the counters and the fsm; cell contents are not reset
// an output stall holds the result register and pauses retiring; inputs wait in idle only
module note_pairing_retire_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [3:0]  i_channel,
    input  logic [31:0] i_event_time,
    input  logic [6:0]  i_tone,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [31:0] o_gap_ticks,
    output logic        o_gap_present,
    output logic        o_gap_implied,
    output logic        o_group_break,
    output logic [6:0]  o_tone_out,
    output logic [31:0] o_duration,
    output logic        o_last
);

    localparam int E = nprq_pkg::ENTRIES;
    localparam int CW = nprq_pkg::CNTW;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_RETIRE = 4'b0100,
        ST_ERR    = 4'b1000
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [31:0]   r_last_start;
    logic [31:0]   r_nat;
    logic [1:0]    r_same;
    nprq_pkg::t_kind r_err_kind;
    logic [3:0]    r_q_channel;
    logic [6:0]    r_q_tone;
    logic [31:0]   r_q_time;

    logic              r_o_valid;
    nprq_pkg::t_kind   r_o_kind;
    logic [31:0]       r_o_gap;
    logic              r_o_present, r_o_implied, r_o_break, r_o_last;
    logic [6:0]        r_o_tone;
    logic [31:0]       r_o_dur;

    nprq_pkg::t_cell_ctl ctl;
    nprq_pkg::t_entry    entry [E];
    logic [E-1:0]        tok_out, hits, wr, occ;

    logic in_acc, slot_free, full, found, exhausted, head_done, do_retire, load_out;

    assign o_stall   = (r_state != ST_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign slot_free = !r_o_valid || !i_stall;
    assign full      = (r_count >= CW'(E));
    assign found     = |hits;
    assign exhausted = tok_out[E-1];
    assign head_done = (r_count != '0) && entry[0].done;
    assign do_retire = (r_state == ST_RETIRE) && slot_free && head_done;
    // a new result enters the output register
    assign load_out  = do_retire || ((r_state == ST_ERR) && slot_free);

    // broadcast control for the chain
    always_comb begin
        ctl.shift            = do_retire;
        ctl.q_channel        = r_q_channel;
        ctl.q_tone           = r_q_tone;
        ctl.q_time           = r_q_time;
        ctl.wdata.done       = 1'b0;
        ctl.wdata.channel    = i_channel;
        ctl.wdata.start      = i_event_time;
        ctl.wdata.duration   = '0;
        ctl.wdata.tone       = i_tone;
    end

    genvar k;
    generate
        for (k = 0; k < E; k++) begin : g_cell
            logic            tok_in;
            nprq_pkg::t_entry nxt;
            assign occ[k] = (r_count > CW'(k));
            assign wr[k]  = in_acc && !i_mode && !full && (r_count == CW'(k));
            if (k == 0) begin : g_first
                assign tok_in = in_acc && i_mode;
            end else begin : g_rest
                assign tok_in = tok_out[k-1];
            end
            if (k == E - 1) begin : g_end
                assign nxt = '0;
            end else begin : g_mid
                assign nxt = entry[k+1];
            end
            nprq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_wr    (wr[k]),
                .i_occ   (occ[k]),
                .i_tok   (tok_in),
                .i_next  (nxt),
                .o_entry (entry[k]),
                .o_tok   (tok_out[k]),
                .o_hit   (hits[k])
            );
        end
    endgenerate

    // record for the note at the head
    logic [31:0] diff, nat_dec, n_nat;
    logic [1:0]  same_inc, n_same;
    logic        rec_last;

    always_comb begin
        diff     = entry[0].start - r_last_start;
        same_inc = (r_same == 2'd3) ? r_same : r_same + 2'd1;
        nat_dec  = (r_nat > diff) ? r_nat - diff : '0;
        if (diff != '0) begin
            n_same = '0;
            n_nat  = nat_dec;
        end else begin
            n_same = same_inc;
            n_nat  = r_nat;
        end
        if (n_nat < entry[0].duration) begin
            n_nat = entry[0].duration;
        end
        // last unless the next cell is also done and pending
        rec_last = !((r_count > CW'(1)) && entry[1].done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_last_start <= '0;
            r_nat        <= '0;
            r_same       <= '0;
            r_o_valid    <= 1'b0;
            r_err_kind   <= nprq_pkg::KIND_OVERFLOW;
        end else begin
            r_o_valid <= load_out || (r_o_valid && i_stall);
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_q_channel <= i_channel;
                        r_q_tone    <= i_tone;
                        r_q_time    <= i_event_time;
                        if (i_mode) begin
                            r_state <= ST_SEARCH;
                        end else if (full) begin
                            r_err_kind <= nprq_pkg::KIND_OVERFLOW;
                            r_state    <= ST_ERR;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                ST_SEARCH: begin
                    if (found) begin
                        r_state <= ST_RETIRE;
                    end else if (exhausted) begin
                        r_err_kind <= nprq_pkg::KIND_NOMATCH;
                        r_state    <= ST_ERR;
                    end
                end
                ST_RETIRE: begin
                    if (!head_done) begin
                        r_state <= ST_IDLE;
                    end else if (slot_free) begin
                        r_o_kind    <= nprq_pkg::KIND_RECORD;
                        r_o_gap     <= diff;
                        r_o_present <= (diff != '0);
                        r_o_implied <= (diff != '0) && (r_nat == diff);
                        r_o_break   <= (diff != '0) && (same_inc > 2'd1);
                        r_o_tone    <= entry[0].tone;
                        r_o_dur     <= entry[0].duration;
                        r_o_last    <= rec_last;
                        r_same      <= n_same;
                        r_nat       <= n_nat;
                        if (diff != '0) begin
                            r_last_start <= entry[0].start;
                        end
                        r_count <= r_count - CW'(1);
                        if (rec_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ERR: begin
                    if (slot_free) begin
                        r_o_kind    <= r_err_kind;
                        r_o_gap     <= '0;
                        r_o_present <= 1'b0;
                        r_o_implied <= 1'b0;
                        r_o_break   <= 1'b0;
                        r_o_tone    <= '0;
                        r_o_dur     <= '0;
                        r_o_last    <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_gap_ticks   = r_o_gap;
    assign o_gap_present = r_o_present;
    assign o_gap_implied = r_o_implied;
    assign o_group_break = r_o_break;
    assign o_tone_out    = r_o_tone;
    assign o_duration    = r_o_dur;
    assign o_last        = r_o_last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(E)) else $error("pending count above ring size");
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hits)) else $error("more than one cell matched");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode) |=> o_stall) else $error("note off not searched");
    a_retire_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_retire |=> (r_count == $past(r_count) - CW'(1)))
        else $error("retire did not pop head");
`endif

endmodule
